/* hw/rtl/lvlft_pkg.sv */
package lvlft_pkg;

  // Field widths.
  localparam int FREQ_W    = 16;
  localparam int POS_W     = 20;
  localparam int DIST_W    = 18;
  localparam int STABLE_W  = 4;
  localparam int ACCEL_W   = 5;
  localparam int SAMPLE_W  = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;

  // Search limits.
  localparam int MAX_ACCEL_STEPS = 10;
  localparam int LOCK_COUNT      = 10;
  localparam int LOOP_LIMIT      = 100;

  // Register values after reset.
  localparam logic [FREQ_W-1:0] RST_TARGET_FREQ = 16'd5500;
  localparam logic [FREQ_W-1:0] RST_AIR_FREQ    = 16'd6500;
  localparam logic [FREQ_W-1:0] RST_OIL_FREQ    = 16'd4500;
  localparam logic [FREQ_W-1:0] RST_LOCK_BAND   = 16'd20;
  localparam logic [POS_W-1:0]  RST_BLIND_ZONE  = 20'd0;
  localparam logic [POS_W-1:0]  RST_TANK_HEIGHT = 20'hFFFFF;

  typedef enum logic [2:0] {
    ST_TRACKING      = 3'd0,
    ST_LOCKED        = 3'd1,
    ST_LOOP_LIMIT    = 3'd2,
    ST_OVERSPEED     = 3'd3,
    ST_LEVEL_HIGH    = 3'd4,
    ST_BLIND_WAIT    = 3'd5,
    ST_BLIND_CLEARED = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_FREQ = 3'd0,
    CFG_AIR_FREQ    = 3'd1,
    CFG_OIL_FREQ    = 3'd2,
    CFG_LOCK_BAND   = 3'd3,
    CFG_BLIND_ZONE  = 3'd4,
    CFG_TANK_HEIGHT = 3'd5,
    CFG_FOLLOW_MODE = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [FREQ_W-1:0] target_frequency;
    logic [FREQ_W-1:0] air_freq;
    logic [FREQ_W-1:0] oil_freq;
    logic [FREQ_W-1:0] lock_band;
    logic [POS_W-1:0]  blind_zone;
    logic [POS_W-1:0]  tank_height;
    logic              follow_mode;
  } cfg_t;

  typedef struct packed {
    logic                cmd;
    logic [FREQ_W-1:0]   sensor_frequency;
    logic [POS_W-1:0]    probe_position;
  } sample_t;

  typedef struct packed {
    logic [STABLE_W-1:0] stable_count;
    logic [ACCEL_W-1:0]  down_accel_count;
    logic [ACCEL_W-1:0]  up_accel_count;
    logic [SAMPLE_W-1:0] sample_count;
    logic                blind_waiting;
    status_t             finished_status;
    logic [POS_W-1:0]    level_register;
  } state_t;

  typedef struct packed {
    logic [DIST_W-1:0]   move_distance;
    dir_t                move_direction;
    logic [STABLE_W-1:0] stable_samples;
    status_t             status;
    logic                level_valid;
    logic [POS_W-1:0]    level_value;
  } result_t;

endpackage

/* hw/rtl/lvlft_if.sv */
// Sample channel: one frequency sample or restart command per word.
interface lvlft_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [lvlft_pkg::FREQ_W-1:0] sensor_frequency;
  logic [lvlft_pkg::POS_W-1:0]  probe_position;

  modport source (output valid, cmd, sensor_frequency, probe_position, input ready);
  modport sink   (input valid, cmd, sensor_frequency, probe_position, output ready);
endinterface

// Result channel: one move decision per sample word.
interface lvlft_out_if;
  logic                           valid;
  logic                           ready;
  logic [lvlft_pkg::DIST_W-1:0]   move_distance;
  logic [1:0]                     move_direction;
  logic [lvlft_pkg::STABLE_W-1:0] stable_samples;
  logic [2:0]                     status;
  logic                           level_valid;
  logic [lvlft_pkg::POS_W-1:0]    level_value;

  modport source (output valid, move_distance, move_direction, stable_samples, status,
                  level_valid, level_value, input ready);
  modport sink   (input valid, move_distance, move_direction, stable_samples, status,
                  level_valid, level_value, output ready);
endinterface

/* hw/rtl/level_interface_frequency_tracker.sv */
// Level-interface frequency tracker.
// Words arrive on the sample channel (valid/ready): either a frequency sample
// with the current probe position, or a restart command. For every accepted
// word exactly one word leaves on the result channel, carrying the probe move
// (distance in 0.01 mm and direction), the in-band sample count, the search
// status and the recorded level.
// Thresholds and limits come from the write port (wr_en, wr_index, wr_data);
// write it only while no sample is in flight.
// An accepted word is registered in the input register, and its result is
// loaded into the output register once that register is free. One word is
// accepted every cycle while the result register is free or being emptied; the
// search state is read and updated by a single pass of logic between the input
// register and the output register.
// Reset clears the search state and the level register, empties both
// registers and loads the default thresholds. When the receiver holds ready
// low, the result register keeps its word and one more word waits in the input
// register; the sample channel stalls only when both are full.
module level_interface_frequency_tracker (
  input  logic                            clk,
  input  logic                            rst,
  lvlft_in_if.sink                        sample,
  lvlft_out_if.source                     result,
  input  logic                            wr_en,
  input  logic [lvlft_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [lvlft_pkg::CFG_DAT_W-1:0] wr_data
);

  lvlft_pkg::cfg_t    cfg;
  lvlft_pkg::state_t  state, state_next;
  lvlft_pkg::sample_t sample_word;
  lvlft_pkg::result_t result_word, result_next;
  logic               sample_valid;
  logic               result_valid;
  logic               advance;

  lvlft_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  lvlft_step u_step (
    .cfg        (cfg),
    .state      (state),
    .smp        (sample_word),
    .state_next (state_next),
    .res        (result_next)
  );

  // Handshake: the input word moves on whenever the result register is free.
  assign advance      = sample_valid && (!result_valid || result.ready);
  assign sample.ready = !rst && (!sample_valid || advance);

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (sample.ready) begin
      sample_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      sample_word.cmd              <= sample.cmd;
      sample_word.sensor_frequency <= sample.sensor_frequency;
      sample_word.probe_position   <= sample.probe_position;
    end
  end

  // Search state, updated once per processed word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_word <= result_next;
    end
  end

  assign result.valid          = result_valid;
  assign result.move_distance  = result_word.move_distance;
  assign result.move_direction = result_word.move_direction;
  assign result.stable_samples = result_word.stable_samples;
  assign result.status         = result_word.status;
  assign result.level_valid    = result_word.level_valid;
  assign result.level_value    = result_word.level_value;

  // A finished search never sits in the blind wait.
  assert property (@(posedge clk) disable iff (rst)
    state.finished_status != lvlft_pkg::ST_TRACKING |-> !state.blind_waiting)
    else $error("finished search still waiting in blind zone");

  // The loop counter stops one past the limit.
  assert property (@(posedge clk) disable iff (rst)
    state.sample_count <= lvlft_pkg::SAMPLE_W'(lvlft_pkg::LOOP_LIMIT + 1))
    else $error("sample counter ran past loop limit");

  // After the search has finished, samples give no move and no level update.
  assert property (@(posedge clk) disable iff (rst)
    (advance && !sample_word.cmd && state.finished_status != lvlft_pkg::ST_TRACKING)
    |=> (result_word.move_distance == '0 && result_word.level_valid == 1'b0))
    else $error("finished search produced a move");

  // A move has a direction exactly when its distance is nonzero.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result_word.move_distance == '0) ==
                      (result_word.move_direction == lvlft_pkg::DIR_NONE)))
    else $error("move direction and distance disagree");

  // A waiting input word is not lost while the result side stalls.
  assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !advance) |=> sample_valid)
    else $error("stalled input word dropped");

endmodule

/* hw/rtl/lvlft_cfg.sv */
module lvlft_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [lvlft_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [lvlft_pkg::CFG_DAT_W-1:0] wr_data,
  output lvlft_pkg::cfg_t                 cfg
);

  // Register file, written one register at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_frequency <= lvlft_pkg::RST_TARGET_FREQ;
      cfg.air_freq         <= lvlft_pkg::RST_AIR_FREQ;
      cfg.oil_freq         <= lvlft_pkg::RST_OIL_FREQ;
      cfg.lock_band        <= lvlft_pkg::RST_LOCK_BAND;
      cfg.blind_zone       <= lvlft_pkg::RST_BLIND_ZONE;
      cfg.tank_height      <= lvlft_pkg::RST_TANK_HEIGHT;
      cfg.follow_mode      <= 1'b0;
    end else if (wr_en) begin
      case (lvlft_pkg::cfg_index_t'(wr_index))
        lvlft_pkg::CFG_TARGET_FREQ: begin
          cfg.target_frequency <= wr_data[lvlft_pkg::FREQ_W-1:0];
        end
        lvlft_pkg::CFG_AIR_FREQ: begin
          cfg.air_freq <= wr_data[lvlft_pkg::FREQ_W-1:0];
        end
        lvlft_pkg::CFG_OIL_FREQ: begin
          cfg.oil_freq <= wr_data[lvlft_pkg::FREQ_W-1:0];
        end
        lvlft_pkg::CFG_LOCK_BAND: begin
          cfg.lock_band <= wr_data[lvlft_pkg::FREQ_W-1:0];
        end
        lvlft_pkg::CFG_BLIND_ZONE: begin
          cfg.blind_zone <= wr_data[lvlft_pkg::POS_W-1:0];
        end
        lvlft_pkg::CFG_TANK_HEIGHT: begin
          cfg.tank_height <= wr_data[lvlft_pkg::POS_W-1:0];
        end
        lvlft_pkg::CFG_FOLLOW_MODE: begin
          cfg.follow_mode <= wr_data[0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* hw/rtl/lvlft_step.sv */
module lvlft_step (
  input  lvlft_pkg::cfg_t    cfg,
  input  lvlft_pkg::state_t  state,
  input  lvlft_pkg::sample_t smp,
  output lvlft_pkg::state_t  state_next,
  output lvlft_pkg::result_t res
);

  localparam logic signed [17:0] FAST_ERR    = 18'sd500;
  localparam logic signed [17:0] EDGE_MARGIN = 18'sd200;
  localparam logic [13:0]        ACCEL_STEP  = 14'd400;
  localparam logic signed [19:0] HALVE_BELOW = 20'sd500;
  localparam logic signed [19:0] FLOOR_BELOW = 20'sd60;
  localparam logic [lvlft_pkg::DIST_W-1:0] FLOOR_DIST = 18'd10;
  localparam logic [lvlft_pkg::POS_W-1:0]  HIGH_MARGIN = 20'd1000;

  // Frequency errors, signed, in Hz.
  logic signed [17:0] diff;
  logic signed [17:0] air_gap;
  logic signed [17:0] oil_gap;
  logic signed [17:0] band;

  assign diff    = $signed({2'b00, cfg.target_frequency}) - $signed({2'b00, smp.sensor_frequency});
  assign air_gap = $signed({2'b00, cfg.air_freq}) - $signed({2'b00, smp.sensor_frequency});
  assign oil_gap = $signed({2'b00, smp.sensor_frequency}) - $signed({2'b00, cfg.oil_freq});
  assign band    = $signed({2'b00, cfg.lock_band});

  // Move branch selection, in priority order.
  logic down_fast, down_slow, up_fast, up_slow, in_band;

  assign down_fast = (diff > FAST_ERR) || (air_gap < EDGE_MARGIN);
  assign down_slow = diff > band;
  assign up_fast   = (diff < -FAST_ERR) || (oil_gap < EDGE_MARGIN);
  assign up_slow   = diff < -band;
  assign in_band   = (diff <= band) && (diff >= -band) &&
                     (air_gap > EDGE_MARGIN) && (oil_gap > EDGE_MARGIN);

  // Accelerated step: 4 mm for each earlier accelerated sample plus the error.
  logic [13:0]        accel_dn, accel_up;
  logic signed [19:0] diff_x;

  assign accel_dn = 14'(state.down_accel_count) * ACCEL_STEP;
  assign accel_up = 14'(state.up_accel_count) * ACCEL_STEP;
  assign diff_x   = 20'(diff);

  logic [5:0]         over, lower;
  logic signed [19:0] dist_raw, move_len;
  lvlft_pkg::dir_t    dir_raw;

  always_comb begin
    over     = '0;
    lower    = '0;
    dist_raw = '0;
    dir_raw  = lvlft_pkg::DIR_NONE;
    if (down_fast) begin
      over     = {1'b0, state.down_accel_count} + 6'd1;
      dist_raw = $signed({6'b0, accel_dn}) + diff_x;
      dir_raw  = lvlft_pkg::DIR_DOWN;
    end else if (down_slow) begin
      dist_raw = diff_x;
      dir_raw  = lvlft_pkg::DIR_DOWN;
    end else if (up_fast) begin
      lower    = {1'b0, state.up_accel_count} + 6'd1;
      dist_raw = $signed({6'b0, accel_up}) - diff_x;
      dir_raw  = lvlft_pkg::DIR_UP;
    end else if (up_slow) begin
      dist_raw = -diff_x;
      dir_raw  = lvlft_pkg::DIR_UP;
    end
  end

  assign move_len = in_band ? 20'sd0 : dist_raw;

  // Short steps are halved; anything under 0.3 mm after halving becomes 0.1 mm.
  logic [lvlft_pkg::DIST_W-1:0] out_dist;
  lvlft_pkg::dir_t              out_dir;
  logic signed [19:0]           dist_half;

  assign dist_half = move_len >>> 1;

  always_comb begin
    out_dist = '0;
    out_dir  = lvlft_pkg::DIR_NONE;
    if (move_len != 20'sd0) begin
      out_dir = dir_raw;
      if (move_len < FLOOR_BELOW) begin
        out_dist = FLOOR_DIST;
      end else if (move_len < HALVE_BELOW) begin
        out_dist = dist_half[lvlft_pkg::DIST_W-1:0];
      end else begin
        out_dist = move_len[lvlft_pkg::DIST_W-1:0];
      end
    end
  end

  // Counter updates for a tracked sample.
  logic [lvlft_pkg::STABLE_W-1:0] stable_inc;
  logic                           overspeed;
  logic                           pos_high;
  logic                           pos_blind;

  assign stable_inc = in_band ? ((&state.stable_count) ? state.stable_count
                                                       : state.stable_count + 1'b1)
                              : '0;
  assign overspeed  = (over > 6'(lvlft_pkg::MAX_ACCEL_STEPS)) ||
                      (lower > 6'(lvlft_pkg::MAX_ACCEL_STEPS));
  assign pos_high   = (cfg.tank_height < HIGH_MARGIN) ||
                      (smp.probe_position >= cfg.tank_height - HIGH_MARGIN);
  assign pos_blind  = smp.probe_position < cfg.blind_zone;

  // Sample flow: restart, finished, blind wait, loop limit, then tracking.
  always_comb begin
    state_next         = state;
    res.move_distance  = '0;
    res.move_direction = lvlft_pkg::DIR_NONE;
    res.status         = lvlft_pkg::ST_TRACKING;
    res.level_valid    = 1'b0;
    if (smp.cmd) begin
      state_next.stable_count     = '0;
      state_next.down_accel_count = '0;
      state_next.up_accel_count   = '0;
      state_next.sample_count     = '0;
      state_next.blind_waiting    = 1'b0;
      state_next.finished_status  = lvlft_pkg::ST_TRACKING;
    end else if (state.finished_status != lvlft_pkg::ST_TRACKING) begin
      res.status = state.finished_status;
    end else if (state.blind_waiting) begin
      if (diff < 18'sd0) begin
        state_next.blind_waiting = 1'b0;
        if (state.stable_count >= lvlft_pkg::STABLE_W'(lvlft_pkg::LOCK_COUNT)) begin
          state_next.finished_status = lvlft_pkg::ST_LOCKED;
          res.status                 = lvlft_pkg::ST_LOCKED;
        end else begin
          res.status = lvlft_pkg::ST_BLIND_CLEARED;
        end
      end else begin
        res.status = lvlft_pkg::ST_BLIND_WAIT;
      end
    end else if (state.sample_count > lvlft_pkg::SAMPLE_W'(lvlft_pkg::LOOP_LIMIT)) begin
      state_next.finished_status = lvlft_pkg::ST_LOOP_LIMIT;
      res.status                 = lvlft_pkg::ST_LOOP_LIMIT;
    end else begin
      state_next.sample_count     = state.sample_count + 1'b1;
      state_next.down_accel_count = over[5] ? '1 : over[lvlft_pkg::ACCEL_W-1:0];
      state_next.up_accel_count   = lower[5] ? '1 : lower[lvlft_pkg::ACCEL_W-1:0];
      state_next.stable_count     = stable_inc;
      res.move_distance           = out_dist;
      res.move_direction          = out_dir;
      if (overspeed) begin
        state_next.finished_status = lvlft_pkg::ST_OVERSPEED;
        res.status                 = lvlft_pkg::ST_OVERSPEED;
      end else begin
        if (cfg.follow_mode) begin
          state_next.level_register = smp.probe_position;
          res.level_valid           = 1'b1;
        end
        if (pos_high) begin
          state_next.finished_status = lvlft_pkg::ST_LEVEL_HIGH;
          res.status                 = lvlft_pkg::ST_LEVEL_HIGH;
        end else if (pos_blind) begin
          state_next.blind_waiting = 1'b1;
          res.status               = lvlft_pkg::ST_BLIND_WAIT;
        end else if (stable_inc >= lvlft_pkg::STABLE_W'(lvlft_pkg::LOCK_COUNT)) begin
          state_next.finished_status = lvlft_pkg::ST_LOCKED;
          res.status                 = lvlft_pkg::ST_LOCKED;
        end
      end
    end
    res.stable_samples = state_next.stable_count;
    res.level_value    = state_next.level_register;
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
  import lvlft_pkg::*;

  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;
  localparam int   IDLE_PCT    = 17;
  localparam int   HOLD_CYCLES = 60;
  localparam int   STALL_LIMIT = 2000;
  localparam int   FREQ_MAX    = (1 << FREQ_W) - 1;
  localparam int   POS_MAX     = (1 << POS_W) - 1;

  typedef enum int {EP_LOCK, EP_OVERSPEED, EP_LOOP, EP_BLIND, EP_HIGH, EP_NOISE} episode_t;

  // Tracks the search state, predicts the move word of each sample word and
  // compares the result words against those predictions in order.
  class move_scoreboard;
    cfg_t             cfg;
    int               stable_count, down_accel, up_accel, sample_count;
    logic             blind_wait;
    status_t          finished;
    logic [POS_W-1:0] level;
    result_t          expected_moves[$];
    int               errors, results_checked;
    int               reached[8];

    function new();
      cfg = '{RST_TARGET_FREQ, RST_AIR_FREQ, RST_OIL_FREQ, RST_LOCK_BAND,
              RST_BLIND_ZONE, RST_TANK_HEIGHT, 1'b0};
      stable_count = 0;
      down_accel = 0;
      up_accel = 0;
      sample_count = 0;
      blind_wait = 1'b0;
      finished = ST_TRACKING;
      level = '0;
      errors = 0;
      results_checked = 0;
      foreach (reached[i]) reached[i] = 0;
    endfunction

    function result_t make_result(longint step, dir_t dir, status_t st, logic upd);
      result_t r;
      r.move_distance  = DIST_W'(step);
      r.move_direction = dir;
      r.stable_samples = STABLE_W'(stable_count);
      r.status         = st;
      r.level_valid    = upd;
      r.level_value    = level;
      return r;
    endfunction

    function result_t predict_move(sample_t s);
      longint cur, pos, tgt, air, oil, band, diff, span, half, step;
      int     over, lower;
      dir_t   dir;
      status_t st;
      logic   upd;
      cur  = s.sensor_frequency;
      pos  = s.probe_position;
      tgt  = cfg.target_frequency;
      air  = cfg.air_freq;
      oil  = cfg.oil_freq;
      band = cfg.lock_band;
      diff = tgt - cur;
      span = 0;
      step = 0;
      over = 0;
      lower = 0;
      dir = DIR_NONE;
      st = ST_TRACKING;
      upd = 1'b0;

      // A restart clears the search but keeps the recorded level.
      if (s.cmd == CMD_RESTART) begin
        stable_count = 0;
        down_accel = 0;
        up_accel = 0;
        sample_count = 0;
        blind_wait = 1'b0;
        finished = ST_TRACKING;
        return make_result(0, DIR_NONE, ST_TRACKING, 1'b0);
      end
      if (finished != ST_TRACKING) return make_result(0, DIR_NONE, finished, 1'b0);

      // In the blind zone only a frequency above the target ends the wait.
      if (blind_wait) begin
        if (cur <= tgt) return make_result(0, DIR_NONE, ST_BLIND_WAIT, 1'b0);
        blind_wait = 1'b0;
        if (stable_count >= LOCK_COUNT) begin
          finished = ST_LOCKED;
          return make_result(0, DIR_NONE, ST_LOCKED, 1'b0);
        end
        return make_result(0, DIR_NONE, ST_BLIND_CLEARED, 1'b0);
      end
      if (sample_count > LOOP_LIMIT) begin
        finished = ST_LOOP_LIMIT;
        return make_result(0, DIR_NONE, ST_LOOP_LIMIT, 1'b0);
      end
      sample_count++;

      // Choose the direction; far from the target or near air or oil the
      // step grows by 4 mm per consecutive accelerated sample.
      if (diff > 500 || air - cur < 200) begin
        over = down_accel + 1;
        span = 400 * over + diff - 400;
        dir = DIR_DOWN;
      end else if (diff > band) begin
        span = diff;
        dir = DIR_DOWN;
      end else if (diff < -500 || cur - oil < 200) begin
        lower = up_accel + 1;
        span = -diff + 400 * lower - 400;
        dir = DIR_UP;
      end else if (diff < -band) begin
        span = -diff;
        dir = DIR_UP;
      end
      down_accel = (over > 31) ? 31 : over;
      up_accel = (lower > 31) ? 31 : lower;

      if (diff <= band && diff >= -band && air - cur > 200 && cur - oil > 200) begin
        if (stable_count < 15) stable_count++;
        span = 0;
      end else begin
        stable_count = 0;
      end

      // Short steps are halved with a floor of 0.1 mm; long ones saturate.
      if (span != 0) begin
        half = (span < 500) ? span : 2 * span;
        step = (half < 60) ? 10 : half / 2;
        if (step > 262143) step = 262143;
      end else begin
        dir = DIR_NONE;
      end

      if (over > MAX_ACCEL_STEPS || lower > MAX_ACCEL_STEPS) begin
        finished = ST_OVERSPEED;
        return make_result(step, dir, ST_OVERSPEED, 1'b0);
      end

      // Position check: high level first, then the blind zone, then lock.
      if (cfg.follow_mode) begin
        level = s.probe_position;
        upd = 1'b1;
      end
      if (pos >= longint'(cfg.tank_height) - 1000) begin
        finished = ST_LEVEL_HIGH;
        st = ST_LEVEL_HIGH;
      end else if (pos < longint'(cfg.blind_zone)) begin
        blind_wait = 1'b1;
        st = ST_BLIND_WAIT;
      end else if (stable_count >= LOCK_COUNT) begin
        finished = ST_LOCKED;
        st = ST_LOCKED;
      end
      return make_result(step, dir, st, upd);
    endfunction

    function void note_sample(sample_t s);
      result_t r;
      r = predict_move(s);
      reached[int'(r.status)]++;
      expected_moves.push_back(r);
    endfunction

    function void mismatch(string field, logic [63:0] want, logic [63:0] seen);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_checked++;
      if (expected_moves.size() == 0) begin
        errors++;
        $display("%0t: result word with no sample waiting, expected none, actual %h",
                 $time, got);
        return;
      end
      want = expected_moves.pop_front();
      if (got.move_distance !== want.move_distance)
        mismatch("move_distance", want.move_distance, got.move_distance);
      if (got.move_direction !== want.move_direction)
        mismatch("move_direction", want.move_direction, got.move_direction);
      if (got.stable_samples !== want.stable_samples)
        mismatch("stable_samples", want.stable_samples, got.stable_samples);
      if (got.status !== want.status)
        mismatch("status", want.status, got.status);
      if (got.level_valid !== want.level_valid)
        mismatch("level_valid", want.level_valid, got.level_valid);
      if (got.level_value !== want.level_value)
        mismatch("level_value", want.level_value, got.level_value);
    endfunction

    function int moves_due();
      return expected_moves.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 wr_en;
  cfg_index_t           wr_index;
  logic [CFG_DAT_W-1:0] wr_data;
  bit                   idle_on = 1'b1;
  bit                   hold_request = 1'b0;
  int                   words_sent = 0;
  move_scoreboard       sb;

  lvlft_in_if  in_ch();
  lvlft_out_if out_ch();

  level_interface_frequency_tracker i_dut (
    .clk      (clk),
    .rst      (rst),
    .sample   (in_ch),
    .result   (out_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Random value in [lo, hi].
  function automatic longint pick(longint lo, longint hi);
    return lo + longint'($urandom_range(32'(hi - lo)));
  endfunction

  // Frequency at a given offset from the current target, clipped to the field.
  function automatic logic [FREQ_W-1:0] freq_at(longint offset);
    longint v;
    v = longint'(sb.cfg.target_frequency) + offset;
    if (v < 0) v = 0;
    else if (v > FREQ_MAX) v = FREQ_MAX;
    return FREQ_W'(v);
  endfunction

  // Position between the blind zone and the high limit, when there is room.
  function automatic logic [POS_W-1:0] pos_ok();
    longint lo, hi;
    lo = sb.cfg.blind_zone;
    hi = longint'(sb.cfg.tank_height) - 1001;
    if (hi < lo) return POS_W'($urandom);
    return POS_W'(pick(lo, hi));
  endfunction

  function automatic logic [POS_W-1:0] pos_high();
    longint lo;
    lo = longint'(sb.cfg.tank_height) - 1000;
    if (lo < 0) lo = 0;
    return POS_W'(pick(lo, POS_MAX));
  endfunction

  function automatic logic [POS_W-1:0] pos_blind();
    if (sb.cfg.blind_zone == 0) return pos_ok();
    return POS_W'(pick(0, longint'(sb.cfg.blind_zone) - 1));
  endfunction

  // Offers one sample word, with random idle cycles, until it is taken.
  task automatic send_word(logic cmd, logic [FREQ_W-1:0] freq, logic [POS_W-1:0] pos);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.sensor_frequency <= freq;
    in_ch.probe_position <= pos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
  endtask

  task automatic apply_config(cfg_t c);
    write_reg(CFG_TARGET_FREQ, CFG_DAT_W'(c.target_frequency));
    write_reg(CFG_AIR_FREQ, CFG_DAT_W'(c.air_freq));
    write_reg(CFG_OIL_FREQ, CFG_DAT_W'(c.oil_freq));
    write_reg(CFG_LOCK_BAND, CFG_DAT_W'(c.lock_band));
    write_reg(CFG_BLIND_ZONE, c.blind_zone);
    write_reg(CFG_TANK_HEIGHT, c.tank_height);
    write_reg(CFG_FOLLOW_MODE, CFG_DAT_W'(c.follow_mode));
    @(negedge clk);
    wr_en <= 1'b0;
    sb.cfg = c;
  endtask

  // Stops offering words and waits until every predicted result has come.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.moves_due() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One search from a restart, shaped toward a particular way of ending.
  task automatic run_episode();
    episode_t kind;
    int       roll, n, sign;
    longint   b, mag;
    roll = $urandom_range(99);
    if (roll < 22) kind = EP_LOCK;
    else if (roll < 40) kind = EP_OVERSPEED;
    else if (roll < 48) kind = EP_LOOP;
    else if (roll < 68) kind = EP_BLIND;
    else if (roll < 82) kind = EP_HIGH;
    else kind = EP_NOISE;
    b = (sb.cfg.lock_band > 150) ? 150 : sb.cfg.lock_band;
    sign = $urandom_range(1) ? 1 : -1;

    send_word(CMD_RESTART, FREQ_W'($urandom), POS_W'($urandom));
    case (kind)
      EP_LOCK: begin
        // Mostly in-band words, now and then one outside the band.
        n = int'(pick(8, 13));
        repeat (n) begin
          if ($urandom_range(11) == 0) begin
            mag = pick(b + 1, b + 300);
            send_word(CMD_SAMPLE, freq_at(sign * mag), pos_ok());
          end else begin
            send_word(CMD_SAMPLE, freq_at(pick(-b, b)), pos_ok());
          end
        end
      end
      EP_OVERSPEED: begin
        n = int'(pick(11, 14));
        repeat (n) send_word(CMD_SAMPLE, freq_at(sign * pick(501, 5000)), pos_ok());
      end
      EP_LOOP: begin
        // Small errors of alternating sign, just outside the capped band, run toward the loop limit.
        repeat (LOOP_LIMIT + 4) begin
          mag = pick(b + 1, b + 100);
          send_word(CMD_SAMPLE, freq_at(sign * mag), pos_ok());
          sign = -sign;
        end
      end
      EP_BLIND: begin
        n = int'(pick(0, LOCK_COUNT - 1));
        repeat (n) send_word(CMD_SAMPLE, freq_at(pick(-b, b)), pos_ok());
        if ($urandom_range(1)) send_word(CMD_SAMPLE, freq_at(pick(-b, b)), pos_blind());
        else send_word(CMD_SAMPLE, freq_at(pick(-600, 600)), pos_blind());
        n = int'(pick(1, 6));
        repeat (n) send_word(CMD_SAMPLE, freq_at(pick(-300, 300)), POS_W'($urandom));
        send_word(CMD_SAMPLE, freq_at(pick(1, 300)), pos_ok());
        n = int'(pick(0, 3));
        repeat (n) send_word(CMD_SAMPLE, freq_at(pick(-b, b)), pos_ok());
      end
      EP_HIGH: begin
        n = int'(pick(0, 4));
        repeat (n) send_word(CMD_SAMPLE, freq_at(pick(-700, 700)), pos_ok());
        send_word(CMD_SAMPLE, freq_at(pick(-700, 700)), pos_high());
        n = int'(pick(1, 2));
        repeat (n) send_word(CMD_SAMPLE, FREQ_W'($urandom), POS_W'($urandom));
      end
      default: begin
        n = int'(pick(6, 15));
        repeat (n)
          send_word(($urandom_range(7) == 0) ? CMD_RESTART : CMD_SAMPLE,
                    FREQ_W'($urandom), POS_W'($urandom));
      end
    endcase
  endtask

  // Result side: random back-pressure, plus one long hold when asked.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Both channels are observed at the rising edge.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      sb.note_sample({in_ch.cmd, in_ch.sensor_frequency, in_ch.probe_position});
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.move_distance, out_ch.move_direction, out_ch.stable_samples,
                       out_ch.status, out_ch.level_valid, out_ch.level_value});
  end

  // Ends the run when no word moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
    $display("level_interface_frequency_tracker test failed");
    $finish;
  end

  initial begin
    cfg_t setting;
    int   budget;
    sb = new();
    wr_en = 1'b0;
    wr_index = CFG_TARGET_FREQ;
    wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_SAMPLE;
    in_ch.sensor_frequency = '0;
    in_ch.probe_position = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words on the settings after reset.
    send_word(CMD_SAMPLE, 16'd5500, '0);
    send_word(CMD_SAMPLE, '0, POS_MAX);
    send_word(CMD_SAMPLE, 16'd5500, 20'd1000);
    send_word(CMD_RESTART, FREQ_MAX, POS_MAX);
    // At the air side the accelerated step goes negative and takes the floor.
    send_word(CMD_SAMPLE, FREQ_MAX, 20'd12345);
    send_word(CMD_RESTART, '0, '0);
    send_word(CMD_SAMPLE, 16'd5530, 20'd5000);
    send_word(CMD_SAMPLE, 16'd5400, 20'd5000);
    send_word(CMD_SAMPLE, 16'd4900, 20'd5000);
    send_word(CMD_SAMPLE, 16'd4900, 20'd5000);
    send_word(CMD_SAMPLE, 16'd6100, 20'd5000);
    send_word(CMD_SAMPLE, 16'd5000, 20'd5000);
    send_word(CMD_SAMPLE, 16'd5520, 20'd5000);
    send_word(CMD_SAMPLE, 16'd5479, 20'd5000);
    send_word(CMD_RESTART, 16'd5500, 20'd5000);
    repeat (LOCK_COUNT) send_word(CMD_SAMPLE, 16'd5500, 20'd5000);
    send_word(CMD_SAMPLE, 16'd5500, 20'd5000);

    // Random searches over several register settings.
    for (int phase = 1; phase <= 6; phase++) begin
      settle();
      if (phase == 1 || phase == 4) hold_request = 1'b1;
      case (phase)
        1: setting = '{RST_TARGET_FREQ, RST_AIR_FREQ, RST_OIL_FREQ, RST_LOCK_BAND,
                       20'd20000, 20'd900000, 1'b1};
        2: setting = '0;
        3: setting = '1;
        5: setting = '{RST_TARGET_FREQ, RST_AIR_FREQ, RST_OIL_FREQ, 16'd0,
                       20'd3000, RST_TANK_HEIGHT, 1'b1};
        default: begin
          setting.target_frequency = FREQ_W'(pick(3000, 60000));
          setting.air_freq = FREQ_W'(setting.target_frequency + pick(500, 3000));
          setting.oil_freq = FREQ_W'(setting.target_frequency - pick(500, 3000));
          setting.lock_band = FREQ_W'(pick(0, 60));
          setting.blind_zone = POS_W'(pick(0, 100000));
          setting.tank_height = POS_W'(setting.blind_zone + pick(20000, 900000));
          setting.follow_mode = 1'($urandom_range(1));
        end
      endcase
      apply_config(setting);
      idle_on = (phase != 5);
      budget = words_sent + ((phase == 2 || phase == 3) ? 80 : 322);
      while (words_sent < budget) run_episode();
    end
    settle();

    $display("Checked %0d results for %0d sample words over seven register settings.",
             sb.results_checked, words_sent);
    $display("Results seen: locked %0d, loop limit %0d, overspeed %0d, level high %0d,",
             sb.reached[ST_LOCKED], sb.reached[ST_LOOP_LIMIT], sb.reached[ST_OVERSPEED],
             sb.reached[ST_LEVEL_HIGH]);
    $display("  blind wait %0d, blind cleared %0d.",
             sb.reached[ST_BLIND_WAIT], sb.reached[ST_BLIND_CLEARED]);
    if (sb.errors == 0) begin
      $display("level_interface_frequency_tracker test passed");
    end else begin
      $display("level_interface_frequency_tracker test failed");
    end
    $finish;
  end

endmodule
